>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the accelerometer filter.
// Include with the bare file name; each macro takes a label, a property and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication on the rising clock edge, disabled in reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Assert a property on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> hw/rtl/abgkf_pkg.sv
// Package for the accelerometer bias, glitch and Kalman filter block.
// Holds widths, register codes, reset values and the divider control struct.
package abgkf_pkg;
   localparam int DataW = 32;
   localparam int BiasSamples = 20;
   localparam int CntW = 9;
   localparam int SumW = 40;
   localparam logic signed [DataW-1:0] GravityQ16 = 32'sd642253;
   localparam logic [DataW-1:0] ProcNoiseReset = 32'd655;
   localparam logic [DataW-1:0] MeasNoiseReset = 32'd6554;
   localparam logic [30:0] JumpThreshReset = 31'd32768;
   localparam logic [2:0] HoldLimitReset = 3'd3;
   localparam int AddrW = 5;

   typedef enum logic [2:0] {
      REG_PROC_X = 3'd0,
      REG_PROC_Y = 3'd1,
      REG_PROC_Z = 3'd2,
      REG_MEAS_X = 3'd3,
      REG_MEAS_Y = 3'd4,
      REG_MEAS_Z = 3'd5,
      REG_THRESH = 3'd6,
      REG_HOLD   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;
endpackage

>>> hw/rtl/abgkf_if.sv
// Valid/ready channel interfaces for the accelerometer filter.
// Depends on abgkf_pkg for the data width.
interface abgkf_req_if;
   import abgkf_pkg::*;
   logic valid;
   logic ready;
   logic signed [DataW-1:0] accel_x_in;
   logic signed [DataW-1:0] accel_y_in;
   logic signed [DataW-1:0] accel_z_in;
   modport source (output valid, accel_x_in, accel_y_in, accel_z_in, input ready);
   modport sink (input valid, accel_x_in, accel_y_in, accel_z_in, output ready);
endinterface

interface abgkf_rsp_if;
   import abgkf_pkg::*;
   logic valid;
   logic ready;
   logic calibrated;
   logic signed [DataW-1:0] filtered_x;
   logic signed [DataW-1:0] filtered_y;
   logic signed [DataW-1:0] filtered_z;
   logic signed [DataW-1:0] cleaned_x;
   logic signed [DataW-1:0] cleaned_y;
   logic signed [DataW-1:0] cleaned_z;
   logic [2:0] glitch_mask;
   modport source (output valid, calibrated, filtered_x, filtered_y, filtered_z,
      cleaned_x, cleaned_y, cleaned_z, glitch_mask, input ready);
   modport sink (input valid, calibrated, filtered_x, filtered_y, filtered_z,
      cleaned_x, cleaned_y, cleaned_z, glitch_mask, output ready);
endinterface

>>> hw/rtl/accel_bias_glitch_kalman_filter_core.sv
// Top level of the accelerometer bias, glitch and Kalman filter.
// Depends on abgkf_pkg, the channel interfaces, abgkf_divider and assert_macros.svh.
//
// Usage: one transfer on req carries a raw three-axis sample; exactly one
// transfer on rsp follows with the filtered result. The block takes one
// sample at a time. A sample before calibration produces an all-zero result
// through the S_OUT state and the output register. The sample that completes
// the bias count first runs three bias divisions, one per axis. Every
// calibrated sample then runs the three axes one after the other, each using
// the shared bit-serial divider once for the gain. The divider yields one
// quotient bit per cycle. Reset clears the bias count, the filter state and
// the registers to their reset values. When the receiver stalls, the result
// waits in the output register and req.ready stays low until it is taken.
// Configuration must be written through the APB-style csr port only while
// the block is idle; the block itself does not enforce this.
module accel_bias_glitch_kalman_filter_core (
   input  logic clock,
   input  logic reset,
   abgkf_req_if.sink req,
   abgkf_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [abgkf_pkg::AddrW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import abgkf_pkg::*;
`include "assert_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_BIAS, S_BIAS_WAIT, S_CLEAN, S_GAIN, S_GAIN_WAIT, S_MUL, S_UPD, S_NEXT,
      S_OUT
   } state_type;

   logic [31:0] proc_ff [3];
   logic [31:0] meas_ff [3];
   logic [30:0] thresh_ff;
   logic [2:0] hold_ff;

   state_type state_ff;
   logic [CntW-1:0] count_ff;
   logic calib_ff;
   logic first_ff;
   logic signed [SumW-1:0] sum_ff [3];
   logic signed [31:0] bias_ff [3];
   logic signed [31:0] last_ff [3];
   logic [3:0] run_ff [3];
   logic signed [31:0] est_ff [3];
   logic [31:0] var_ff [3];
   logic signed [31:0] samp_ff [3];
   logic signed [31:0] clean_ff [3];
   logic [2:0] mask_ff;
   logic [1:0] axis_ff;
   logic [32:0] p1_ff;
   logic [16:0] k_ff;
   logic signed [33:0] dif_ff;
   logic signed [51:0] prod_ff;
   logic [48:0] pprod_ff;
   logic out_valid_ff;
   logic div_start;
   logic [63:0] div_dividend;
   logic [32:0] div_divisor;
   logic [63:0] div_q;
   div_ctrl_type div_ctrl;
   logic neg_ff;

   // Write decode.
   logic wr_en;
   logic [2:0] wr_idx;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign wr_idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_PROC_X: csr_prdata = proc_ff[0];
         REG_PROC_Y: csr_prdata = proc_ff[1];
         REG_PROC_Z: csr_prdata = proc_ff[2];
         REG_MEAS_X: csr_prdata = meas_ff[0];
         REG_MEAS_Y: csr_prdata = meas_ff[1];
         REG_MEAS_Z: csr_prdata = meas_ff[2];
         REG_THRESH: csr_prdata = {1'b0, thresh_ff};
         REG_HOLD:   csr_prdata = {29'd0, hold_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            proc_ff[i] <= ProcNoiseReset;
            meas_ff[i] <= MeasNoiseReset;
         end
         thresh_ff <= JumpThreshReset;
         hold_ff <= HoldLimitReset;
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         case (reg_index_type'(wr_idx))
            REG_PROC_X: proc_ff[0] <= csr_pwdata;
            REG_PROC_Y: proc_ff[1] <= csr_pwdata;
            REG_PROC_Z: proc_ff[2] <= csr_pwdata;
            REG_MEAS_X: meas_ff[0] <= csr_pwdata;
            REG_MEAS_Y: meas_ff[1] <= csr_pwdata;
            REG_MEAS_Z: meas_ff[2] <= csr_pwdata;
            REG_THRESH: thresh_ff <= csr_pwdata[30:0];
            REG_HOLD:   hold_ff <= csr_pwdata[2:0];
            default:    hold_ff <= hold_ff;
         endcase
      end
   end

   abgkf_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .quotient(div_q), .ctrl(div_ctrl)
   );

   // Combinational helpers for the current axis.
   logic signed [SumW-1:0] cur_sum;
   logic [SumW-1:0] sum_mag;
   logic signed [32:0] sub33;
   logic signed [31:0] clean_sat;
   logic signed [33:0] jump;
   logic [33:0] jump_mag;
   logic glitch;
   logic [33:0] p1_full;
   logic [32:0] gain_den;
   logic signed [33:0] bias_div;
   logic signed [32:0] bias_g;
   logic signed [31:0] bias_sat;
   logic signed [33:0] est_new;
   logic [51:0] prod_mag;
   logic [35:0] rnd_mag;
   logic signed [31:0] cur_samp, cur_last, cur_est;
   logic [3:0] cur_run;
   logic signed [31:0] sx, sy, sz;

   assign cur_samp = samp_ff[axis_ff];
   assign cur_last = last_ff[axis_ff];
   assign cur_est = est_ff[axis_ff];
   assign cur_run = run_ff[axis_ff];
   assign cur_sum = sum_ff[axis_ff];
   assign sum_mag = cur_sum[SumW-1] ? SumW'(-cur_sum) : SumW'(cur_sum);
   assign sub33 = 33'(cur_samp) - 33'(bias_ff[axis_ff]);
   assign clean_sat = (sub33 > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (sub33 < -33'sh0_8000_0000) ? 32'sh8000_0000 : sub33[31:0];
   assign jump = 34'(clean_sat) - 34'(cur_last);
   assign jump_mag = jump[33] ? 34'(-jump) : 34'(jump);
   assign glitch = (cur_run <= {1'b0, hold_ff}) && (jump_mag > {3'b000, thresh_ff});
   assign p1_full = 34'(var_ff[axis_ff]) + 34'(proc_ff[axis_ff]);
   assign gain_den = 33'(p1_ff) + 33'(meas_ff[axis_ff]);
   assign bias_div = neg_ff ? -$signed({1'b0, div_q[32:0]}) : $signed({1'b0, div_q[32:0]});
   assign bias_g = (axis_ff == 2'd2) ? 33'(bias_div) + 33'(GravityQ16) : 33'(bias_div);
   assign bias_sat = (bias_g > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (bias_g < -33'sh0_8000_0000) ? 32'sh8000_0000 : bias_g[31:0];
   assign prod_mag = prod_ff[51] ? 52'(-prod_ff) : 52'(prod_ff);
   assign rnd_mag = 36'((prod_mag + 52'd32768) >> 16);
   assign est_new = prod_ff[51] ? 34'(cur_est) - $signed({1'b0, rnd_mag[32:0]})
                                : 34'(cur_est) + $signed({1'b0, rnd_mag[32:0]});
   assign sx = req.accel_x_in;
   assign sy = (req.accel_y_in == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -req.accel_y_in;
   assign sz = (req.accel_z_in == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -req.accel_z_in;

   always_comb begin
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor = '0;
      if (state_ff == S_BIAS) begin
         div_start = 1'b1;
         div_dividend = 64'(sum_mag) + 64'(BiasSamples / 2);
         div_divisor = 33'(BiasSamples);
      end else if (state_ff == S_GAIN) begin
         div_start = 1'b1;
         div_dividend = {15'd0, p1_ff, 16'd0};
         div_divisor = gain_den;
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         calib_ff <= 1'b0;
         first_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         axis_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
            bias_ff[i] <= '0;
            last_ff[i] <= '0;
            run_ff[i] <= '0;
            est_ff[i] <= '0;
            var_ff[i] <= '0;
         end
      end else begin
         if (out_valid_ff && rsp.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  samp_ff[0] <= sx;
                  samp_ff[1] <= sy;
                  samp_ff[2] <= sz;
                  mask_ff <= '0;
                  axis_ff <= '0;
                  if (count_ff < CntW'(BiasSamples)) begin
                     sum_ff[0] <= sum_ff[0] + SumW'(sx);
                     sum_ff[1] <= sum_ff[1] + SumW'(sy);
                     sum_ff[2] <= sum_ff[2] + SumW'(sz);
                     count_ff <= count_ff + 1'b1;
                     if (count_ff == CntW'(BiasSamples - 1)) state_ff <= S_BIAS;
                     else state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_CLEAN;
                  end
               end
            end
            S_BIAS: begin
               neg_ff <= cur_sum[SumW-1];
               state_ff <= S_BIAS_WAIT;
            end
            S_BIAS_WAIT: begin
               if (div_ctrl.done) begin
                  bias_ff[axis_ff] <= bias_sat;
                  if (axis_ff == 2'd2) begin
                     axis_ff <= '0;
                     calib_ff <= 1'b1;
                     first_ff <= 1'b1;
                     state_ff <= S_CLEAN;
                  end else begin
                     axis_ff <= axis_ff + 2'd1;
                     state_ff <= S_BIAS;
                  end
               end
            end
            S_CLEAN: begin
               // On the completing sample, the last value equals the cleaned one.
               if (glitch && !first_ff) begin
                  clean_ff[axis_ff] <= cur_last;
                  run_ff[axis_ff] <= cur_run + 4'd1;
                  mask_ff[axis_ff] <= 1'b1;
               end else begin
                  clean_ff[axis_ff] <= clean_sat;
                  last_ff[axis_ff] <= clean_sat;
                  run_ff[axis_ff] <= '0;
               end
               p1_ff <= p1_full[32] ? 33'h0_FFFF_FFFF : p1_full[32:0];
               if (calib_ff) state_ff <= S_GAIN;
            end
            S_GAIN: state_ff <= S_GAIN_WAIT;
            S_GAIN_WAIT: begin
               if (div_ctrl.done) begin
                  k_ff <= (gain_den == '0) ? 17'd0 : div_q[16:0];
                  dif_ff <= 34'(clean_ff[axis_ff]) - 34'(cur_est);
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff <= 52'(dif_ff) * $signed({35'd0, k_ff});
               pprod_ff <= 49'((50'(17'h10000 - k_ff) * 50'(p1_ff[31:0])) >> 16);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               est_ff[axis_ff] <= (est_new > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                  (est_new < -34'sh0_8000_0000) ? 32'sh8000_0000 :
                                  est_new[31:0];
               var_ff[axis_ff] <= pprod_ff[31:0];
               last_ff[axis_ff] <= clean_ff[axis_ff];
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (axis_ff == 2'd2) begin
                  state_ff <= S_OUT;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
                  state_ff <= S_CLEAN;
               end
            end
            S_OUT: begin
               out_valid_ff <= 1'b1;
               first_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The divisor is latched in the divider; a zero divisor yields zero gain.
   assign rsp.valid = out_valid_ff;
   assign rsp.calibrated = calib_ff;
   assign rsp.filtered_x = calib_ff ? est_ff[0] : '0;
   assign rsp.filtered_y = calib_ff ? est_ff[1] : '0;
   assign rsp.filtered_z = calib_ff ? est_ff[2] : '0;
   assign rsp.cleaned_x = calib_ff ? clean_ff[0] : '0;
   assign rsp.cleaned_y = calib_ff ? clean_ff[1] : '0;
   assign rsp.cleaned_z = calib_ff ? clean_ff[2] : '0;
   assign rsp.glitch_mask = calib_ff ? mask_ff : '0;

   `ASSERT_CLK(a_no_accept_busy, req.valid && req.ready |-> state_ff == S_IDLE && !out_valid_ff, "accept while busy")
   `ASSERT_CLK(a_div_done_wait, div_ctrl.done |-> state_ff == S_BIAS_WAIT || state_ff == S_GAIN_WAIT, "divider done out of place")
   `ASSERT_CLK(a_count_cap, count_ff <= CntW'(BiasSamples), "bias count overran")
   `ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == S_IDLE && !out_valid_ff, "reset left block busy")
endmodule

>>> hw/rtl/abgkf_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on abgkf_pkg; divides a 64-bit dividend by a 33-bit divisor.
module abgkf_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic [63:0] quotient,
   output abgkf_pkg::div_ctrl_type ctrl
);
   import abgkf_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [33:0] trial;
   logic [34:0] diff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[32:0], quo_ff[63]};
      diff = {1'b0, trial} - {2'b00, den_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[34]) begin
            rem_in = diff[33:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign ctrl.start = start;
   assign ctrl.busy = busy_ff;
   assign ctrl.done = done_ff;
endmodule

>>> dv/accel_bias_glitch_kalman_filter_core_tb.sv
// Self-checking testbench for the accelerometer bias, glitch and Kalman filter core.
// A queue-fed driver, a clocked monitor and an in-line predictor check every transfer.
// Depends on abgkf_pkg, the channel interfaces and the core RTL.
`timescale 1ns / 1ps

module accel_bias_glitch_kalman_filter_core_tb;
   import abgkf_pkg::*;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
   } sample_type;

   typedef struct packed {
      logic calibrated;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [2:0] mask;
   } filt_result_type;

   localparam longint CycleLimit = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [AddrW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   abgkf_req_if req ();
   abgkf_rsp_if rsp ();

   accel_bias_glitch_kalman_filter_core uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of registers and state.
   logic [31:0] q_noise [3];
   logic [31:0] r_noise [3];
   logic [30:0] thresh;
   logic [2:0] hold_lim;
   int unsigned n_summed;
   bit bias_known;
   longint acc_sum [3];
   longint bias [3];
   longint prev_clean [3];
   int unsigned run_len [3];
   longint est [3];
   longint var_p [3];

   sample_type pending_samples[$];
   filt_result_type expected_results[$];
   bit quiet_tail = 1'b0;
   bit req_fire = 1'b0;
   int errors = 0;
   longint cycles = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   task automatic predict_sample(sample_type smp);
      longint s [3];
      longint c, d;
      logic [63:0] p1, den, k;
      longint prod;
      filt_result_type r;
      r = '0;
      s[0] = smp.ax;
      s[1] = clamp32(-longint'(smp.ay));
      s[2] = clamp32(-longint'(smp.az));
      if (n_summed < BiasSamples) begin
         for (int a = 0; a < 3; a++) acc_sum[a] += s[a];
         n_summed++;
         if (n_summed == BiasSamples) begin
            for (int a = 0; a < 3; a++) bias[a] = clamp32(round_div(acc_sum[a], BiasSamples));
            bias[2] = clamp32(bias[2] + GravityQ16);
            for (int a = 0; a < 3; a++) prev_clean[a] = clamp32(s[a] - bias[a]);
            bias_known = 1'b1;
         end
      end
      if (bias_known) begin
         r.calibrated = 1'b1;
         for (int a = 0; a < 3; a++) begin
            c = clamp32(s[a] - bias[a]);
            d = c - prev_clean[a];
            if (d < 0) d = -d;
            if (run_len[a] <= hold_lim && d > longint'(thresh)) begin
               c = prev_clean[a];
               run_len[a] = (run_len[a] + 1) & 15;
               r.mask[a] = 1'b1;
            end else begin
               run_len[a] = 0;
            end
            prev_clean[a] = c;
            p1 = 64'(var_p[a]) + 64'(q_noise[a]);
            if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
            den = p1 + 64'(r_noise[a]);
            k = (den != 0) ? (p1 << 16) / den : 64'd0;
            prod = (c - est[a]) * longint'(k);
            est[a] = clamp32(est[a] + round_div(prod, 65536));
            var_p[a] = longint'(((64'd65536 - k) * p1) >> 16);
            if (a == 0) begin r.fx = est[a][31:0]; r.cx = c[31:0]; end
            if (a == 1) begin r.fy = est[a][31:0]; r.cy = c[31:0]; end
            if (a == 2) begin r.fz = est[a][31:0]; r.cz = c[31:0]; end
         end
      end
      expected_results = {expected_results, r};
   endtask

   function automatic logic [31:0] rand_accel(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 40000)) - 20000);
         2: return 32'($signed($urandom_range(0, 400000)) - 200000);
         default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
   endfunction

   // Driver: presents queued samples, with random idle bursts.
   int idle_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            predict_sample(pending_samples.pop_front());
            if (!quiet_tail && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 3);
         end
         if (req_fire || !req.valid) begin
            if (idle_left > 0) begin
               idle_left--;
               req.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req.valid <= 1'b1;
               req.accel_x_in <= pending_samples[0].ax;
               req.accel_y_in <= pending_samples[0].ay;
               req.accel_z_in <= pending_samples[0].az;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stalls and output checking.
   int stall_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      filt_result_type got, want;
      cycles++;
      req_fire = !reset && req.valid && req.ready;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.calibrated, rsp.filtered_x, rsp.filtered_y, rsp.filtered_z,
                rsp.cleaned_x, rsp.cleaned_y, rsp.cleaned_z, rsp.glitch_mask};
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer %h", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= AddrW'(idx) << 2; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_PROC_X, REG_PROC_Y, REG_PROC_Z: q_noise[int'(idx)] = val;
         REG_MEAS_X, REG_MEAS_Y, REG_MEAS_Z: r_noise[int'(idx) - 3] = val;
         REG_THRESH: thresh = val[30:0];
         default: hold_lim = val[2:0];
      endcase
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || expected_results.size() > 0) @(negedge clock);
      repeat (500) @(negedge clock);
   endtask

   task automatic add_random(int count, int mode_hi);
      sample_type smp;
      for (int i = 0; i < count; i++) begin
         smp.ax = rand_accel($urandom_range(0, mode_hi));
         smp.ay = rand_accel($urandom_range(0, mode_hi));
         smp.az = rand_accel($urandom_range(0, mode_hi));
         pending_samples = {pending_samples, smp};
      end
   endtask

   initial begin
      sample_type smp;
      for (int a = 0; a < 3; a++) begin
         q_noise[a] = ProcNoiseReset; r_noise[a] = MeasNoiseReset;
         acc_sum[a] = 0; bias[a] = 0; prev_clean[a] = 0;
         run_len[a] = 0; est[a] = 0; var_p[a] = 0;
      end
      thresh = JumpThreshReset; hold_lim = HoldLimitReset;
      n_summed = 0; bias_known = 1'b0;
      req.valid = 1'b0; req.accel_x_in = '0; req.accel_y_in = '0; req.accel_z_in = '0;
      rsp.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Calibration with extremes, then glitch runs around the hold limit.
      for (int i = 0; i < 20; i++) begin
         smp.ax = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
         smp.ay = (i % 3) ? 32'h8000_0000 : 32'sd1000;
         smp.az = -32'sd642253 + 32'(i);
         pending_samples = {pending_samples, smp};
      end
      for (int i = 0; i < 6; i++) begin
         smp.ax = (i < 5) ? 32'sd900000 : 32'sd0;
         smp.ay = 32'h8000_0000; smp.az = 32'h7FFF_FFFF;
         pending_samples = {pending_samples, smp};
      end
      add_random(100, 3);
      drain();

      csr_write(REG_PROC_X, 32'hFFFF_FFFF);
      csr_write(REG_PROC_Y, 32'd0);
      csr_write(REG_PROC_Z, 32'd12345);
      csr_write(REG_MEAS_X, 32'd1);
      csr_write(REG_MEAS_Y, 32'hFFFF_FFFF);
      csr_write(REG_MEAS_Z, 32'd65536);
      csr_write(REG_THRESH, 32'd0);
      csr_write(REG_HOLD, 32'd7);
      add_random(500, 3);
      drain();

      csr_write(REG_THRESH, 32'h7FFF_FFFF);
      csr_write(REG_HOLD, 32'd0);
      csr_write(REG_MEAS_X, 32'd6554);
      add_random(400, 2);
      drain();

      for (int p = 0; p < 8; p++) csr_write(reg_index_type'(p), $urandom);
      csr_write(REG_MEAS_X, $urandom_range(1, 100000));
      csr_write(REG_MEAS_Y, $urandom_range(1, 100000));
      csr_write(REG_MEAS_Z, $urandom_range(1, 100000));
      csr_write(REG_THRESH, $urandom_range(1000, 100000));
      add_random(600, 3);
      drain();

      quiet_tail = 1'b1;
      add_random(200, 2);
      drain();

      if (errors == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
